>>> src/kwm_pkg.sv
// Shared types and codes for the k-way sorted merge core.
// No dependencies; imported by kwm_ram users, kwm_list_table and the top level.
`default_nettype none

package kwm_pkg;

    // Field widths fixed by the stream format
    localparam int DATA_W      = 32;
    localparam int CMD_W       = 2;
    localparam int LIDX_W      = 3;
    localparam int STAT_W      = 2;
    localparam int CFG_W       = 4;
    localparam int IN_TDATA_W  = 40;   // list_index + push_value, padded to bytes
    localparam int OUT_TDATA_W = 32;
    localparam int IDX_MAX_W   = 5;    // wide enough for up to 32 lists

    typedef logic [CMD_W-1:0]  t_cmd;
    typedef logic [STAT_W-1:0] t_status;
    typedef logic [1:0]        t_tbl_op;

    // Commands
    localparam t_cmd CMD_PUSH  = 2'd0;
    localparam t_cmd CMD_POP   = 2'd1;
    localparam t_cmd CMD_CLEAR = 2'd2;
    localparam t_cmd CMD_NOP   = 2'd3;

    // Result status
    localparam t_status ST_OK     = 2'd0;
    localparam t_status ST_FULL   = 2'd1;
    localparam t_status ST_UNUSED = 2'd2;
    localparam t_status ST_EMPTY  = 2'd3;

    // List table operations
    localparam t_tbl_op TBL_NONE  = 2'd0;
    localparam t_tbl_op TBL_PUSH  = 2'd1;
    localparam t_tbl_op TBL_POP   = 2'd2;
    localparam t_tbl_op TBL_CLEAR = 2'd3;

    typedef struct packed {
        t_tbl_op               op;
        logic [IDX_MAX_W-1:0]  idx;
    } t_tbl_req;

endpackage

`default_nettype wire

>>> src/kwm_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module kwm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> src/kwm_list_table.sv
// Per-list fill counts and read positions of the merge core.
// Depends on kwm_pkg for the table request struct and operation codes.
`default_nettype none

module kwm_list_table
    import kwm_pkg::*;
#(
    parameter int LISTS_MAX  = 8,
    parameter int LIST_DEPTH = 64
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire t_tbl_req                            i_req,
    output logic [$clog2(LIST_DEPTH+1)-1:0]          o_fill   [LISTS_MAX],
    output logic [$clog2(LIST_DEPTH)-1:0]            o_rdpos  [LISTS_MAX],
    output logic [LISTS_MAX-1:0]                     o_nonempty
);

    localparam int LW  = $clog2(LISTS_MAX);
    localparam int FCW = $clog2(LIST_DEPTH+1);
    localparam int RPW = $clog2(LIST_DEPTH);

    logic [FCW-1:0] r_fill  [LISTS_MAX];
    logic [RPW-1:0] r_rdpos [LISTS_MAX];
    logic [LW-1:0]  sel;
    logic [FCW-1:0] rd_next;

    assign sel     = i_req.idx[LW-1:0];
    assign rd_next = FCW'(r_rdpos[sel]) + FCW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LISTS_MAX; i++) begin
                r_fill[i]  <= '0;
                r_rdpos[i] <= '0;
            end
        end else begin
            case (i_req.op)
                TBL_PUSH: begin
                    r_fill[sel] <= r_fill[sel] + FCW'(1);
                end
                TBL_POP: begin
                    // drained list gives its space back
                    if (rd_next >= r_fill[sel]) begin
                        r_fill[sel]  <= '0;
                        r_rdpos[sel] <= '0;
                    end else begin
                        r_rdpos[sel] <= rd_next[RPW-1:0];
                    end
                end
                TBL_CLEAR: begin
                    for (int i = 0; i < LISTS_MAX; i++) begin
                        r_fill[i]  <= '0;
                        r_rdpos[i] <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < LISTS_MAX; i++) begin
            o_fill[i]     = r_fill[i];
            o_rdpos[i]    = r_rdpos[i];
            o_nonempty[i] = (FCW'(r_rdpos[i]) != r_fill[i]);
        end
    end

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.op == TBL_CLEAR) |=> (o_nonempty == '0))
        else $error("lists not empty after clear");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.op == TBL_POP) |-> o_nonempty[sel])
        else $error("pop issued on an empty list");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.op == TBL_PUSH) |-> (r_fill[sel] < FCW'(LIST_DEPTH)))
        else $error("push issued on a full list");

endmodule

`default_nettype wire

>>> src/k_way_sorted_merge_core.sv
// K-way sorted merge core: LISTS_MAX lists of signed 32-bit values kept in one
// RAM, one LIST_DEPTH-word region per list, with fill counts and read positions
// in a small register table. Every input transfer yields exactly one result
// transfer. A push, a clear or the spare command goes from acceptance through
// S_OUT into the result register; a pop scans every list through the single
// RAM read port, one head per cycle, then passes S_DRAIN, S_UPD and S_OUT. Input
// ready is high only in S_IDLE, so the next item is taken only once the last
// one has reached the result register. The scan over the read port makes a pop
// the slowest command. While the receiver holds off a result, the next finished
// command waits for the result register and input ready stays low. Ties between
// equal heads go to the lower list. No clearing pass is needed after reset: list
// contents are only read below the fill count.
// Depends on kwm_pkg, kwm_ram and kwm_list_table.
`default_nettype none

module k_way_sorted_merge_core
    import kwm_pkg::*;
#(
    parameter int LISTS_MAX  = 8,
    parameter int LIST_DEPTH = 64
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // configuration: lists_in_use
    input  wire logic                   i_cfg_wr_en,
    input  wire logic [CFG_W-1:0]       i_cfg_wr_data,
    // command stream
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,   // [2:0] list_index, [34:3] push_value
    input  wire logic [CMD_W-1:0]       i_s_tuser,   // [1:0] cmd
    // result stream
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0]      o_m_tdata,   // [31:0] popped_value
    output logic [STAT_W-1:0]           o_m_tuser,   // [1:0] status
    output logic                        o_m_tlast    // was_final
);

    localparam int LW    = $clog2(LISTS_MAX);
    localparam int AW    = $clog2(LIST_DEPTH);
    localparam int FCW   = $clog2(LIST_DEPTH+1);
    localparam int RAM_AW = LW + AW;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_UPD   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [2:0]        r_state, n_state;
    logic [CFG_W-1:0]  r_lists;
    logic [LW-1:0]     r_scan;
    logic              r_cmp_v;
    logic [LW-1:0]     r_cmp_idx;
    logic              r_found;
    logic [LW-1:0]     r_best_idx;
    logic [DATA_W-1:0] r_best_val;
    logic [DATA_W-1:0] r_res_val;
    t_status           r_res_stat;
    logic              r_res_final;
    logic              r_ovalid;
    logic [DATA_W-1:0] r_odata;
    t_status           r_ostat;
    logic              r_olast;

    // ------------------------------------------------------------------
    // Input field decode
    // ------------------------------------------------------------------
    t_cmd              in_cmd;
    logic [LIDX_W-1:0] in_idx;
    logic [DATA_W-1:0] in_val;
    logic [5:0]        in_idx_ext;
    logic [LW-1:0]     in_sel;
    logic              in_fire;

    assign in_cmd     = i_s_tuser;
    assign in_idx     = i_s_tdata[LIDX_W-1:0];
    assign in_val     = i_s_tdata[LIDX_W +: DATA_W];
    assign in_idx_ext = {3'b000, in_idx};
    assign in_sel     = in_idx_ext[LW-1:0];
    assign o_s_tready = (r_state == S_IDLE);
    assign in_fire    = i_s_tvalid && o_s_tready;

    // Active list mask: list 0 always takes part, the rest below lists_in_use
    logic [LISTS_MAX-1:0] act;
    for (genvar g = 0; g < LISTS_MAX; g++) begin : g_act
        if (g == 0) begin : g_first
            assign act[g] = 1'b1;
        end else begin : g_rest
            assign act[g] = ({2'b00, r_lists} > 6'(g));
        end
    end

    // ------------------------------------------------------------------
    // List table and RAM
    // ------------------------------------------------------------------
    t_tbl_req             tbl_req;
    logic [FCW-1:0]       fill  [LISTS_MAX];
    logic [AW-1:0]        rdpos [LISTS_MAX];
    logic [LISTS_MAX-1:0] nonempty;

    kwm_list_table #(
        .LISTS_MAX  (LISTS_MAX),
        .LIST_DEPTH (LIST_DEPTH)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (tbl_req),
        .o_fill     (fill),
        .o_rdpos    (rdpos),
        .o_nonempty (nonempty)
    );

    logic              ram_we;
    logic [RAM_AW-1:0] ram_waddr;
    logic              ram_re;
    logic [RAM_AW-1:0] ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    kwm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (2**RAM_AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (in_val),
        .i_rd_en   (ram_re),
        .i_rd_addr (ram_raddr),
        .o_rd_data (ram_rdata)
    );

    // Push checks: index in range and in use, then room in the list
    logic push_used;
    logic push_full;
    logic push_ok;

    assign push_used = (in_idx_ext < 6'(LISTS_MAX)) && act[in_sel];
    assign push_full = (fill[in_sel] >= FCW'(LIST_DEPTH));
    assign push_ok   = in_fire && (in_cmd == CMD_PUSH) && push_used && !push_full;

    // Append at the tail; fill is below LIST_DEPTH here so it fits AW bits
    assign ram_we    = push_ok;
    assign ram_waddr = {in_sel, fill[in_sel][AW-1:0]};

    // Scan reads one head per cycle
    assign ram_re    = (r_state == S_SCAN);
    assign ram_raddr = {r_scan, rdpos[r_scan]};

    // Head compare in the cycle after the read; strict less keeps the lower list on ties
    logic take_head;
    assign take_head = r_cmp_v && (!r_found || ($signed(ram_rdata) < $signed(r_best_val)));

    // Does anything remain in the lists in use once the winner advances
    logic [FCW-1:0]       best_next;
    logic [LISTS_MAX-1:0] ne_after;
    logic                 others;

    assign best_next = FCW'(rdpos[r_best_idx]) + FCW'(1);

    always_comb begin
        for (int i = 0; i < LISTS_MAX; i++) begin
            if (LW'(i) == r_best_idx) begin
                ne_after[i] = (best_next < fill[i]);
            end else begin
                ne_after[i] = nonempty[i];
            end
        end
        others = |(ne_after & act);
    end

    // ------------------------------------------------------------------
    // Table requests
    // ------------------------------------------------------------------
    always_comb begin
        tbl_req.op  = TBL_NONE;
        tbl_req.idx = IDX_MAX_W'(in_sel);
        if (push_ok) begin
            tbl_req.op = TBL_PUSH;
        end else if (in_fire && (in_cmd == CMD_CLEAR)) begin
            tbl_req.op = TBL_CLEAR;
        end else if ((r_state == S_UPD) && r_found) begin
            tbl_req.op  = TBL_POP;
            tbl_req.idx = IDX_MAX_W'(r_best_idx);
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic out_free;
    assign out_free = !r_ovalid || i_m_tready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = (in_cmd == CMD_POP) ? S_SCAN : S_OUT;
                end
            end
            S_SCAN: begin
                if (r_scan == LW'(LISTS_MAX-1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_UPD;
            S_UPD:   n_state = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_lists  <= CFG_W'(8);
            r_ovalid <= 1'b0;
            r_cmp_v  <= 1'b0;
            r_found  <= 1'b0;
            r_scan   <= '0;
        end else begin
            r_state <= n_state;

            if (i_cfg_wr_en) begin
                r_lists <= i_cfg_wr_data;
            end

            // Result register: load from S_OUT when free, else drop on transfer
            if ((r_state == S_OUT) && out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_m_tready) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    r_scan  <= '0;
                    r_cmp_v <= 1'b0;
                    r_found <= 1'b0;
                end
                S_SCAN: begin
                    r_cmp_v <= act[r_scan] && nonempty[r_scan];
                    if (r_scan != LW'(LISTS_MAX-1)) begin
                        r_scan <= r_scan + LW'(1);
                    end
                end
                default: begin
                    r_cmp_v <= 1'b0;
                end
            endcase

            if (take_head) begin
                r_found <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_SCAN) begin
            r_cmp_idx <= r_scan;
        end
        if (take_head) begin
            r_best_idx <= r_cmp_idx;
            r_best_val <= ram_rdata;
        end

        if (in_fire) begin
            r_res_val   <= '0;
            r_res_final <= 1'b0;
            if ((in_cmd == CMD_PUSH) && !push_used) begin
                r_res_stat <= ST_UNUSED;
            end else if ((in_cmd == CMD_PUSH) && push_full) begin
                r_res_stat <= ST_FULL;
            end else begin
                r_res_stat <= ST_OK;
            end
        end else if (r_state == S_UPD) begin
            if (r_found) begin
                r_res_val   <= r_best_val;
                r_res_stat  <= ST_OK;
                r_res_final <= !others;
            end else begin
                r_res_val   <= '0;
                r_res_stat  <= ST_EMPTY;
                r_res_final <= 1'b0;
            end
        end

        if ((r_state == S_OUT) && out_free) begin
            r_odata <= r_res_val;
            r_ostat <= r_res_stat;
            r_olast <= r_res_final;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_ostat;
    assign o_m_tlast  = r_olast;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_final_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> (o_m_tuser == ST_OK))
        else $error("final flag on a result that is not a good pop");

    a_scan_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |=> (r_state == S_UPD))
        else $error("pop scan did not move to update");

    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !ram_we)
        else $error("store written while a command is in flight");

endmodule

`default_nettype wire

>>> sim/k_way_sorted_merge_core_test.sv
// Self-checking testbench for k_way_sorted_merge_core: random and directed command streams,
// predicted results compared in order against the result stream.
// Depends on kwm_pkg and the k_way_sorted_merge_core RTL.
`default_nettype none

module k_way_sorted_merge_core_test
    import kwm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LISTS      = 8;
    localparam int DEPTH      = 64;
    localparam int HOLD_LEN   = 400;      // long receiver hold-off, in cycles
    localparam int SETTLE_LEN = LISTS + 6;

    // One command as offered on the input stream
    typedef struct packed {
        t_cmd              cmd;
        logic [LIDX_W-1:0] idx;
        logic [DATA_W-1:0] val;
    } merge_cmd_t;

    // One result as seen on the output stream
    typedef struct packed {
        logic [DATA_W-1:0] value;
        t_status           status;
        logic              fin;
    } merge_result_t;

    // DUT inputs start at known values
    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0]       i_cfg_wr_data = '0;
    logic                   i_s_tvalid    = 1'b0;
    logic [IN_TDATA_W-1:0]  i_s_tdata     = '0;
    logic [CMD_W-1:0]       i_s_tuser     = CMD_NOP;
    logic                   i_m_tready    = 1'b0;
    logic                   o_s_tready;
    logic                   o_m_tvalid;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic [STAT_W-1:0]      o_m_tuser;
    logic                   o_m_tlast;

    k_way_sorted_merge_core #(
        .LISTS_MAX  (LISTS),
        .LIST_DEPTH (DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .o_m_tuser     (o_m_tuser),
        .o_m_tlast     (o_m_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Commands waiting to be offered, and results waiting to be seen
    merge_cmd_t    pending_cmds[$];
    merge_result_t merge_expected[$];

    int   cmds_queued  = 0;
    int   cmds_taken   = 0;
    int   results_seen = 0;
    int   errors       = 0;
    logic cmd_taken    = 1'b0;   // input transfer at the last rising edge
    logic calm         = 1'b0;   // suppress random idling on both sides
    int   hold_left    = 0;
    logic hold_done    = 1'b0;
    merge_cmd_t next_cmd;

    // Predictor state: list contents, fill counts, read positions, register copy
    logic [DATA_W-1:0] lst_mem[LISTS][DEPTH];
    int                lst_fill[LISTS];
    int                lst_rd[LISTS];
    logic [CFG_W-1:0]  lists_cfg = 4'd8;

    // Generator state: next sorted value per list
    logic signed [DATA_W-1:0] gen_next[LISTS];

    function automatic int active_lists();
        if (lists_cfg == 0)
            return 1;
        if (lists_cfg > LISTS)
            return LISTS;
        return int'(lists_cfg);
    endfunction

    // Apply one command to the predictor state and return its result
    function automatic merge_result_t merge_predict(input merge_cmd_t c);
        merge_result_t            r;
        int                       n;
        int                       best;
        logic                     found;
        logic                     others;
        logic signed [DATA_W-1:0] head;
        logic signed [DATA_W-1:0] best_val;
        r = '0;
        n = active_lists();
        case (c.cmd)
            CMD_PUSH: begin
                if (int'(c.idx) >= n) begin
                    r.status = ST_UNUSED;
                end else if (lst_fill[c.idx] >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    lst_mem[c.idx][lst_fill[c.idx]] = c.val;
                    lst_fill[c.idx]++;
                end
            end
            CMD_POP: begin
                found    = 1'b0;
                best     = 0;
                best_val = '0;
                // strict less-than keeps ties on the lower list
                for (int i = 0; i < n; i++) begin
                    if (lst_rd[i] < lst_fill[i]) begin
                        head = lst_mem[i][lst_rd[i]];
                        if (!found || head < best_val) begin
                            found    = 1'b1;
                            best     = i;
                            best_val = head;
                        end
                    end
                end
                if (!found) begin
                    r.status = ST_EMPTY;
                end else begin
                    lst_rd[best]++;
                    // a drained list gives its space back
                    if (lst_rd[best] >= lst_fill[best]) begin
                        lst_rd[best]   = 0;
                        lst_fill[best] = 0;
                    end
                    others = 1'b0;
                    for (int i = 0; i < n; i++)
                        if (lst_rd[i] < lst_fill[i])
                            others = 1'b1;
                    r.value = best_val;
                    r.fin   = !others;
                end
            end
            CMD_CLEAR: begin
                for (int i = 0; i < LISTS; i++) begin
                    lst_fill[i] = 0;
                    lst_rd[i]   = 0;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Monitor: take transfers on both streams at the rising edge
    always @(posedge i_clk) begin
        cmd_taken = 1'b0;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                cmd_taken = 1'b1;
                merge_expected.push_back(merge_predict('{cmd: i_s_tuser,
                                                         idx: i_s_tdata[LIDX_W-1:0],
                                                         val: i_s_tdata[LIDX_W +: DATA_W]}));
                cmds_taken++;
            end
            if (o_m_tvalid && i_m_tready) begin
                results_seen++;
                if (merge_expected.size() == 0) begin
                    $display("%0t: unexpected result: expected none, %s %h status %0d last %0b",
                             $realtime, "actual value", o_m_tdata, o_m_tuser, o_m_tlast);
                    errors++;
                end else begin
                    merge_result_t want;
                    want = merge_expected.pop_front();
                    if (o_m_tdata !== want.value) begin
                        $display("%0t: popped_value mismatch: expected %h actual %h",
                                 $realtime, want.value, o_m_tdata);
                        errors++;
                    end
                    if (o_m_tuser !== want.status) begin
                        $display("%0t: status mismatch: expected %0d actual %0d",
                                 $realtime, want.status, o_m_tuser);
                        errors++;
                    end
                    if (o_m_tlast !== want.fin) begin
                        $display("%0t: was_final mismatch: expected %0b actual %0b",
                                 $realtime, want.fin, o_m_tlast);
                        errors++;
                    end
                end
            end
        end
    end

    // Driver: hold a command until its transfer, then advance or idle
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_s_tvalid || cmd_taken)) begin
            if (pending_cmds.size() != 0 && (calm || $urandom_range(0, 99) >= 17)) begin
                next_cmd   = pending_cmds.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tuser  <= next_cmd.cmd;
                i_s_tdata  <= {{(IN_TDATA_W - DATA_W - LIDX_W){1'b0}}, next_cmd.val, next_cmd.idx};
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off once traffic is flowing
    // so that the core backs up and drops its input ready
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left  = hold_left - 1;
            i_m_tready <= 1'b0;
        end else if (!hold_done && results_seen >= 100) begin
            hold_done  = 1'b1;
            hold_left  = HOLD_LEN;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= calm || ($urandom_range(0, 99) >= 17);
        end
    end

    task automatic queue_cmd(input t_cmd c, input int idx, input logic [DATA_W-1:0] v);
        pending_cmds.push_back('{cmd: c, idx: idx[LIDX_W-1:0], val: v});
        cmds_queued++;
    endtask

    // Wait until every command has its result, then let the core drain
    task automatic settle();
        do
            @(negedge i_clk);
        while (cmds_taken != cmds_queued || results_seen != cmds_taken);
        repeat (SETTLE_LEN) @(negedge i_clk);
    endtask

    task automatic write_lists(input logic [CFG_W-1:0] v);
        settle();
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = v;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
        lists_cfg     = v;
    endtask

    // Next value for a list: mostly ascending per list, sometimes anything
    function automatic logic [DATA_W-1:0] sorted_value(input int idx);
        logic [DATA_W-1:0] v;
        if ($urandom_range(0, 99) < 15)
            return $urandom;
        v = gen_next[idx];
        gen_next[idx] = gen_next[idx] + $urandom_range(0, 3);
        return v;
    endfunction

    // Push many values to one list, past its depth, so it reports full
    task automatic fill_list(input int idx, input int count);
        for (int k = 0; k < count; k++)
            queue_cmd(CMD_PUSH, idx, sorted_value(idx));
    endtask

    task automatic random_phase(input int count);
        int n;
        int r;
        int idx;
        n = active_lists();
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            if (r < 48) begin
                // now and then aim outside the lists in use
                idx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, LISTS - 1)
                                                  : $urandom_range(0, n - 1);
                queue_cmd(CMD_PUSH, idx, sorted_value(idx));
            end else if (r < 90) begin
                queue_cmd(CMD_POP, $urandom_range(0, LISTS - 1), $urandom);
            end else if (r < 93) begin
                queue_cmd(CMD_CLEAR, $urandom_range(0, LISTS - 1), $urandom);
            end else begin
                queue_cmd(CMD_NOP, $urandom_range(0, LISTS - 1), $urandom);
            end
        end
    endtask

    initial begin
        for (int i = 0; i < LISTS; i++) begin
            lst_fill[i] = 0;
            lst_rd[i]   = 0;
            gen_next[i] = $signed($urandom_range(0, 40)) - 20;
        end
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: extremes, every command, ties, empty pops, all eight lists
        queue_cmd(CMD_POP,   0, 32'h0);               // nothing held
        queue_cmd(CMD_PUSH,  0, 32'h7fff_ffff);
        queue_cmd(CMD_PUSH,  7, 32'h8000_0000);
        queue_cmd(CMD_PUSH,  3, 32'h0);
        queue_cmd(CMD_PUSH,  3, 32'h0);
        queue_cmd(CMD_PUSH,  5, 32'h0);               // ties with list 3
        queue_cmd(CMD_NOP,   7, 32'hffff_ffff);       // spare command does nothing
        queue_cmd(CMD_POP,   0, 32'h0);
        queue_cmd(CMD_POP,   0, 32'h0);
        queue_cmd(CMD_POP,   0, 32'h0);
        queue_cmd(CMD_POP,   0, 32'h0);
        queue_cmd(CMD_POP,   0, 32'h0);               // last value left
        queue_cmd(CMD_POP,   0, 32'h0);
        queue_cmd(CMD_PUSH,  2, 32'hffff_ffff);
        queue_cmd(CMD_PUSH,  6, 32'h5);
        queue_cmd(CMD_CLEAR, 0, 32'h0);
        queue_cmd(CMD_POP,   0, 32'h0);
        write_lists(4'd2);
        queue_cmd(CMD_PUSH,  2, 32'h1234_5678);       // list not in use
        queue_cmd(CMD_PUSH,  1, 32'h8000_0001);
        queue_cmd(CMD_PUSH,  7, 32'h1);
        queue_cmd(CMD_POP,   0, 32'h0);
        queue_cmd(CMD_POP,   0, 32'h0);

        // One list only: fill past full, then drain past empty
        write_lists(4'd1);
        fill_list(0, DEPTH + 2);
        queue_cmd(CMD_PUSH, 1, 32'h0);
        for (int k = 0; k < DEPTH + 1; k++)
            queue_cmd(CMD_POP, 0, $urandom);

        // Out of range high acts as all lists; fill the top list first
        write_lists(4'd15);
        fill_list(LISTS - 1, DEPTH + 2);
        random_phase(100);

        write_lists(4'd3);
        random_phase(110);

        // Zero acts as one list; values in the other lists are kept
        write_lists(4'd0);
        random_phase(110);

        // Stretch with no idling on either side
        write_lists(4'd8);
        calm = 1'b1;
        random_phase(110);
        settle();
        calm = 1'b0;

        write_lists(4'd5);
        random_phase(110);

        write_lists(4'($urandom_range(0, 15)));
        random_phase(110);

        settle();
        if (errors == 0 && merge_expected.size() == 0) begin
            $display("k_way_sorted_merge_core regression: pass");
        end else begin
            if (merge_expected.size() != 0)
                $display("%0t: %0d results never arrived", $realtime, merge_expected.size());
            $display("k_way_sorted_merge_core regression: fail");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial begin
        #2ms;
        $display("%0t: timeout, %0d results outstanding", $realtime, merge_expected.size());
        $display("k_way_sorted_merge_core regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
src/kwm_pkg.sv
src/kwm_ram.sv
src/kwm_list_table.sv
src/k_way_sorted_merge_core.sv
sim/k_way_sorted_merge_core_test.sv
